// ===== rtl/pid_controller_anti_windup_core_macros.svh =====
// assertion macros for the checker file of the pid controller
`ifndef PID_CONTROLLER_ANTI_WINDUP_CORE_MACROS_SVH
`define PID_CONTROLLER_ANTI_WINDUP_CORE_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PIDAW_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion on the block clock and reset
`define PIDAW_ASSERT(name, prop, msg) `PIDAW_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/pidaw_pkg.sv =====
// shared constants and types of the pid controller with anti-windup
package pidaw_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned MsPerSecond  = 1000;
  localparam int unsigned OpWidth      = DataWidth + 1;
  localparam int unsigned ProdWidth    = 2 * OpWidth;
  localparam int unsigned DivNumWidth  = 48;
  localparam int unsigned DivRadixBits = 4;
  localparam int unsigned DivSteps     = DivNumWidth / DivRadixBits;
  localparam int unsigned DivCntWidth  = $clog2(DivSteps);
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegGainP    = 3'd0,
    RegGainI    = 3'd1,
    RegGainD    = 3'd2,
    RegOutLower = 3'd3,
    RegOutUpper = 3'd4,
    RegTarget   = 3'd5
  } pidaw_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } pidaw_div_stat_t;

endpackage

// ===== rtl/pidaw_mul.sv =====
// shared signed multiplier with registered product
module pidaw_mul (
  input  logic                                       clk_i,
  input  logic signed [pidaw_pkg::OpWidth-1:0]       a_i,
  input  logic signed [pidaw_pkg::OpWidth-1:0]       b_i,
  output logic signed [pidaw_pkg::ProdWidth-1:0]     prod_o
);

  localparam int unsigned OW = pidaw_pkg::OpWidth;
  localparam int unsigned PW = pidaw_pkg::ProdWidth;

  logic signed [PW-1:0] a_x;
  logic signed [PW-1:0] b_x;
  logic signed [PW-1:0] prod_q;

  assign a_x = $signed({{(PW-OW){a_i[OW-1]}}, a_i});
  assign b_x = $signed({{(PW-OW){b_i[OW-1]}}, b_i});

  always_ff @(posedge clk_i) begin
    prod_q <= a_x * b_x;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/pidaw_div.sv =====
// iterative floor divider, signed numerator by unsigned divisor, radix 16
module pidaw_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic signed [pidaw_pkg::DivNumWidth-1:0]    num_i,
  input  logic        [pidaw_pkg::MsWidth-1:0]        den_i,
  output logic signed [pidaw_pkg::DivNumWidth-1:0]    quot_o,
  output pidaw_pkg::pidaw_div_stat_t                  stat_o
);

  localparam int unsigned NW   = pidaw_pkg::DivNumWidth;
  localparam int unsigned MW   = pidaw_pkg::MsWidth;
  localparam int unsigned RB   = pidaw_pkg::DivRadixBits;
  localparam int unsigned CntW = pidaw_pkg::DivCntWidth;
  localparam int unsigned LastCnt = pidaw_pkg::DivSteps - 1;

  logic [NW-1:0]   mag_q, mag_d;
  logic [MW-1:0]   rem_q, rem_d;
  logic [MW-1:0]   den_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [MW:0]     trial;
  logic [MW:0]     trial_sub;
  logic [NW-1:0]   num_abs;
  logic            rem_nz;

  assign num_abs = num_i[NW-1] ? (~num_i + 1'b1) : num_i;

  // four restoring steps per cycle
  always_comb begin
    mag_d     = mag_q;
    rem_d     = rem_q;
    trial     = '0;
    trial_sub = '0;
    for (int i = 0; i < RB; i++) begin
      trial     = {rem_d, mag_d[NW-1]};
      trial_sub = trial - {1'b0, den_q};
      mag_d     = {mag_d[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial_sub[MW-1:0];
        mag_d[0] = 1'b1;
      end else begin
        rem_d = trial[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(LastCnt);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_abs;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NW-1];
    end else if (busy_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  // floor for negative numerators: -(q + (rem != 0))
  assign rem_nz = |rem_q;
  assign quot_o = neg_q ? $signed(~mag_q + {{(NW-1){1'b0}}, ~rem_nz}) : $signed(mag_q);

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/pid_controller_anti_windup_core.sv =====
// top level of the pid controller with derivative on measurement and anti-windup
//
// usage
//   configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
//   (0 gain_p, 1 gain_i, 2 gain_d, 3 out_lower, 4 out_upper, 5 target);
//   writing target also clears the integral; other indexes are ignored
//   input channel: sample_i and elapsed_ms_i under in_valid_i / in_ready_o
//   output channel: drive_o and skipped_o under out_valid_o / out_ready_i
//   one request gives exactly one result
//   a request with zero elapsed time goes from idle straight to the skip state
//   and gives drive 0 and skipped 1 without any arithmetic; every other request
//   runs two radix-16 divisions on the shared divider and five passes through
//   the shared multiplier before its result is ready
//   in_ready_o is high only while the sequencer is idle; a finished result
//   sits in the output register, so the next request is taken while it waits
//   if the receiver stalls, a second result waits in the sequencer until the
//   output register frees up
//   reset: gains 1.0 / 0 / 0, limits full range, target, integral and last
//   sample zero, no result pending
module pid_controller_anti_windup_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [pidaw_pkg::CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [pidaw_pkg::DataWidth-1:0]          cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [pidaw_pkg::DataWidth-1:0]   sample_i,
  input  logic [pidaw_pkg::MsWidth-1:0]            elapsed_ms_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [pidaw_pkg::DataWidth-1:0]   drive_o,
  output logic                                     skipped_o
);

  localparam int unsigned DW   = pidaw_pkg::DataWidth;
  localparam int unsigned FB   = pidaw_pkg::FracBits;
  localparam int unsigned OW   = pidaw_pkg::OpWidth;
  localparam int unsigned PW   = pidaw_pkg::ProdWidth;
  localparam int unsigned NW   = pidaw_pkg::DivNumWidth;
  localparam int unsigned MW   = pidaw_pkg::MsWidth;
  localparam int unsigned SumW = NW + 1;
  localparam int unsigned MsPs = pidaw_pkg::MsPerSecond;

  // sequencer states; the middle ones feed the shared multiplier or wait on the shared divider
  typedef enum logic [3:0] {
    StIdle,
    StErr,
    StMulP,
    StMulI,
    StRate,
    StSlope,
    StHold,
    StWait1,
    StWait2,
    StSum,
    StSkip
  } state_e;

  // saturate a wide signed value to the data word
  function automatic logic signed [DW-1:0] sat_word(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v[PW-1:DW-1] == {(PW-DW+1){v[DW-1]}}) begin
      r = v[DW-1:0];
    end else if (v[PW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  // output limits, lower bound tested first
  function automatic logic signed [DW-1:0] clamp_out(input logic signed [SumW-1:0] v,
                                                     input logic signed [DW-1:0]   lo,
                                                     input logic signed [DW-1:0]   hi);
    logic signed [SumW-1:0] lo_x;
    logic signed [SumW-1:0] hi_x;
    logic signed [DW-1:0]   r;
    lo_x = $signed({{(SumW-DW){lo[DW-1]}}, lo});
    hi_x = $signed({{(SumW-DW){hi[DW-1]}}, hi});
    priority if (v < lo_x) begin
      r = lo;
    end else if (v > hi_x) begin
      r = hi;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  state_e state_q;

  // configuration registers
  logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DW-1:0] out_lower_q, out_upper_q, target_q;

  // loop state
  logic signed [DW-1:0] integral_q;
  logic signed [DW-1:0] prev_q;

  // per-request working registers
  logic signed [DW-1:0] sample_q;
  logic [MW-1:0]        ms_q;
  logic signed [DW-1:0] err_q;
  logic signed [DW-1:0] termp_q;
  logic signed [DW-1:0] ratei_q;
  logic signed [NW-1:0] incnum_q;
  logic signed [DW-1:0] slope_q;
  logic signed [DW-1:0] termd_q;

  // output register
  logic                 out_valid_q;
  logic signed [DW-1:0] out_drive_q;
  logic                 out_skipped_q;

  logic                 in_take;
  logic                 out_free;
  logic                 out_load;

  // shared multiplier
  logic signed [OW-1:0] mul_a;
  logic signed [OW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_neg;
  logic signed [PW-1:0] prod_shr;
  logic signed [PW-1:0] prod_neg_shr;

  // shared divider
  logic                        div_start;
  logic signed [NW-1:0]        div_num;
  logic [MW-1:0]               div_den;
  logic signed [NW-1:0]        quot;
  pidaw_pkg::pidaw_div_stat_t  div_stat;
  logic signed [PW-1:0]        quot_wide;

  // error, measurement step and sums
  logic signed [OW-1:0]   err_diff;
  logic signed [PW-1:0]   err_wide;
  logic signed [OW-1:0]   meas_diff;
  logic signed [SumW-1:0] integ_sum;
  logic signed [SumW-1:0] drive_sum;

  assign in_ready_o = (state_q == StIdle);
  assign in_take    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  // a result enters the output register as the sequencer finishes
  assign out_load   = ((state_q == StSum) || (state_q == StSkip)) && out_free;

  assign err_diff  = $signed({target_q[DW-1], target_q}) - $signed({sample_q[DW-1], sample_q});
  assign err_wide  = $signed({{(PW-OW){err_diff[OW-1]}}, err_diff});
  assign meas_diff = $signed({sample_q[DW-1], sample_q}) - $signed({prev_q[DW-1], prev_q});

  // arithmetic shift right rounds toward minus infinity
  assign prod_shr     = prod >>> FB;
  assign prod_neg     = -prod;
  assign prod_neg_shr = prod_neg >>> FB;
  assign quot_wide    = $signed({{(PW-NW){quot[NW-1]}}, quot});

  assign integ_sum = $signed({{(SumW-DW){integral_q[DW-1]}}, integral_q})
                   + $signed({quot[NW-1], quot});
  assign drive_sum = $signed({{(SumW-DW){termp_q[DW-1]}}, termp_q})
                   + $signed({{(SumW-DW){integral_q[DW-1]}}, integral_q})
                   + $signed({{(SumW-DW){termd_q[DW-1]}}, termd_q});

  // multiplier operand select; the product is registered and shows up in the next cycle
  always_comb begin
    unique case (state_q)
      StMulP: begin
        mul_a = $signed({err_q[DW-1], err_q});
        mul_b = $signed({gain_p_q[DW-1], gain_p_q});
      end
      StMulI: begin
        mul_a = $signed({err_q[DW-1], err_q});
        mul_b = $signed({gain_i_q[DW-1], gain_i_q});
      end
      StRate: begin
        mul_a = meas_diff;
        mul_b = $signed(OW'(MsPs));
      end
      StSlope: begin
        mul_a = $signed({ratei_q[DW-1], ratei_q});
        mul_b = $signed({{(OW-MW){1'b0}}, ms_q});
      end
      StWait1, StWait2: begin
        mul_a = $signed({gain_d_q[DW-1], gain_d_q});
        mul_b = $signed({slope_q[DW-1], slope_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // first division: step * 1000 / ms, second: rate * ms / 1000
  assign div_start = (state_q == StSlope) || ((state_q == StWait1) && div_stat.done);
  assign div_num   = (state_q == StSlope) ? prod[NW-1:0] : incnum_q;
  assign div_den   = (state_q == StSlope) ? ms_q : MW'(MsPs);

  pidaw_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pidaw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      out_drive_q   <= '0;
      out_skipped_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_take) begin
            state_q <= (elapsed_ms_i == '0) ? StSkip : StErr;
          end
        end
        StErr:   state_q <= StMulP;
        StMulP:  state_q <= StMulI;
        StMulI:  state_q <= StRate;
        StRate:  state_q <= StSlope;
        StSlope: state_q <= StHold;
        StHold:  state_q <= StWait1;
        StWait1: begin
          if (div_stat.done) begin
            state_q <= StWait2;
          end
        end
        StWait2: begin
          if (div_stat.done) begin
            state_q <= StSum;
          end
        end
        StSum: begin
          if (out_free) begin
            out_drive_q   <= clamp_out(drive_sum, out_lower_q, out_upper_q);
            out_skipped_q <= 1'b0;
            state_q       <= StIdle;
          end
        end
        StSkip: begin
          if (out_free) begin
            out_drive_q   <= '0;
            out_skipped_q <= 1'b1;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // working registers, loaded as the sequence passes
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
      ms_q     <= elapsed_ms_i;
    end
    unique case (state_q)
      StErr:   err_q    <= sat_word(err_wide);
      StMulI:  termp_q  <= sat_word(prod_shr);
      StRate:  ratei_q  <= sat_word(prod_shr);
      StHold:  incnum_q <= prod[NW-1:0];
      StWait1: begin
        if (div_stat.done) begin
          slope_q <= sat_word(quot_wide);
        end
      end
      StWait2: begin
        if (div_stat.done) begin
          termd_q <= sat_word(prod_neg_shr);
        end
      end
      default: ;
    endcase
  end

  // configuration registers and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= $signed(DW'(1) << FB);
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_lower_q <= {1'b1, {(DW-1){1'b0}}};
      out_upper_q <= {1'b0, {(DW-1){1'b1}}};
      target_q    <= '0;
      integral_q  <= '0;
      prev_q      <= '0;
    end else begin
      // integral update once the rate * ms / 1000 division is done
      if ((state_q == StWait2) && div_stat.done) begin
        integral_q <= clamp_out(integ_sum, out_lower_q, out_upper_q);
      end
      if ((state_q == StSum) && out_free) begin
        prev_q <= sample_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pidaw_pkg::RegGainP:    gain_p_q    <= cfg_wdata_i;
          pidaw_pkg::RegGainI:    gain_i_q    <= cfg_wdata_i;
          pidaw_pkg::RegGainD:    gain_d_q    <= cfg_wdata_i;
          pidaw_pkg::RegOutLower: out_lower_q <= cfg_wdata_i;
          pidaw_pkg::RegOutUpper: out_upper_q <= cfg_wdata_i;
          pidaw_pkg::RegTarget: begin
            target_q   <= cfg_wdata_i;
            integral_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign skipped_o   = out_skipped_q;

endmodule

// ===== rtl/pidaw_checker.sv =====
// port-level checker for the pid controller, bound to the top level
`include "pid_controller_anti_windup_core_macros.svh"

module pidaw_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic signed [pidaw_pkg::DataWidth-1:0]  drive_o,
  input logic                                    skipped_o
);

  // a stalled result holds
  `PIDAW_ASSERT(a_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o), "stall")

  // a skipped request reports zero drive
  `PIDAW_ASSERT(a_skip_zero, out_valid_o && skipped_o |-> drive_o == '0, "skip not zero")

  // the sequencer is not ready in the cycle after it takes a request
  `PIDAW_ASSERT(a_busy, in_valid_i && in_ready_o |=> !in_ready_o, "ready after request")

  // a new result is loaded only as the sequencer returns to idle
  `PIDAW_ASSERT(a_load_idle, $rose(out_valid_o) |-> in_ready_o, "result not at idle")

endmodule

bind pid_controller_anti_windup_core pidaw_checker u_pidaw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_o     (drive_o),
  .skipped_o   (skipped_o)
);

// ===== sim/tb_top.sv =====
// testbench of the pid controller core: predicted drive results under random flow control
`timescale 1ns / 100ps

module tb_top;

  localparam int          ClkHalf      = 4;
  localparam int          ResetCycles  = 11;
  localparam int          MaxGap       = 17;
  // cycles to let the core settle after the last result is back
  localparam int          TailCycles   = 40;
  // no accepted request, result or register write for this long means a hang
  localparam int          QuietLimit   = 2000;
  localparam int          RandomPhases = 10;
  localparam int          PhaseRequests = 100;
  localparam int          DW           = pidaw_pkg::DataWidth;
  localparam int          MsW          = pidaw_pkg::MsWidth;
  localparam int          IdxW         = pidaw_pkg::CfgIdxWidth;
  localparam longint      QMax         = 64'sd2147483647;
  localparam longint      QMin         = -64'sd2147483648;
  localparam longint      MsScale      = 64'sd1000;
  localparam logic [DW-1:0] MaxBits = 32'h7fff_ffff;
  localparam logic [DW-1:0] MinBits = 32'h8000_0000;
  localparam logic [DW-1:0] OneQ    = 32'h0001_0000;
  // indexes past the register map, writes there must be dropped
  localparam logic [IdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [IdxW-1:0] IdxSpareHi = 3'd7;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic                 skipped;
  } drive_result_t;

  // shadow of the controller: registers, integral, last sample and the results still owed
  class drive_scoreboard;
    longint        gain_p, gain_i, gain_d, out_lower, out_upper, target;
    longint        integral_acc, last_meas;
    drive_result_t pending_drive[$];
    int unsigned   mismatches;

    function new();
      gain_p       = 64'sd65536;
      gain_i       = 0;
      gain_d       = 0;
      out_lower    = QMin;
      out_upper    = QMax;
      target       = 0;
      integral_acc = 0;
      last_meas    = 0;
      mismatches   = 0;
    endfunction

    function longint sat_q(longint v);
      if (v > QMax) return QMax;
      if (v < QMin) return QMin;
      return v;
    endfunction

    // lower limit is tested first, so crossed limits give out_lower below it
    function longint clamp_out(longint v);
      if (v < out_lower) return out_lower;
      if (v > out_upper) return out_upper;
      return v;
    endfunction

    // division rounding toward minus infinity, divisor always positive here
    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [DW-1:0] value);
      longint v;
      v = $signed(value);
      case (idx)
        pidaw_pkg::RegGainP:    gain_p = v;
        pidaw_pkg::RegGainI:    gain_i = v;
        pidaw_pkg::RegGainD:    gain_d = v;
        pidaw_pkg::RegOutLower: out_lower = v;
        pidaw_pkg::RegOutUpper: out_upper = v;
        pidaw_pkg::RegTarget: begin
          target       = v;
          integral_acc = 0;
        end
        default: ;
      endcase
    endfunction

    function void take_request(logic signed [DW-1:0] meas, logic [MsW-1:0] ms);
      longint        m_val, dt, err, term_p, rate_i, inc_i, slope, term_d;
      drive_result_t r;
      m_val = meas;
      dt    = longint'(ms);
      if (dt == 0) begin
        // skipped sample: state untouched
        r.drive   = '0;
        r.skipped = 1'b1;
      end else begin
        err          = sat_q(target - m_val);
        term_p       = sat_q((gain_p * err) >>> pidaw_pkg::FracBits);
        rate_i       = sat_q((gain_i * err) >>> pidaw_pkg::FracBits);
        inc_i        = floor_div(rate_i * dt, MsScale);
        integral_acc = clamp_out(integral_acc + inc_i);
        slope        = sat_q(floor_div((m_val - last_meas) * MsScale, dt));
        term_d       = sat_q((-(gain_d * slope)) >>> pidaw_pkg::FracBits);
        r.drive      = clamp_out(term_p + integral_acc + term_d);
        r.skipped    = 1'b0;
        last_meas    = m_val;
      end
      pending_drive.push_back(r);
    endfunction

    function void check_result(logic signed [DW-1:0] drive, logic skipped);
      drive_result_t want;
      if (pending_drive.size() == 0) begin
        $error("result with no request waiting: drive %0d skipped %0b", drive, skipped);
        mismatches++;
        return;
      end
      want = pending_drive.pop_front();
      if (drive !== want.drive) begin
        $error("drive: expected %0d, got %0d", want.drive, drive);
        mismatches++;
      end
      if (skipped !== want.skipped) begin
        $error("skipped: expected %0b, got %0b", want.skipped, skipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [IdxW-1:0]        cfg_idx_i    = '0;
  logic [DW-1:0]          cfg_wdata_i  = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic signed [DW-1:0]   sample_i     = '0;
  logic [MsW-1:0]         elapsed_ms_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic signed [DW-1:0]   drive_o;
  logic                   skipped_o;

  drive_scoreboard sb;
  // phases without any idling on one side or the other
  bit          steady_in  = 1'b0;
  bit          steady_out = 1'b0;
  int unsigned quiet_cycles = 0;

  pid_controller_anti_windup_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .skipped_o    (skipped_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // hang detection: any handshake or register write resets the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one-cycle register write, enable dropped on the following falling edge
  task automatic write_cfg(logic [IdxW-1:0] idx, logic [DW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one request after a random gap, or none in a steady phase, and wait for the accepting edge
  task automatic send_request(logic [DW-1:0] meas, logic [MsW-1:0] ms);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= meas;
    elapsed_ms_i <= ms;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.take_request(meas, ms);
  endtask

  // stop offering requests until every owed result is back, then let the core settle
  task automatic drain(int unsigned tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] small_q(int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span * 65536)) - int'(span * 65536);
    return v;
  endfunction

  function automatic logic [DW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return MinBits;
      1:       return MaxBits;
      2:       return '0;
      3:       return $urandom();
      default: return small_q(4);
    endcase
  endfunction

  // new register set for a random phase, written while the core is idle
  task automatic random_config();
    logic [DW-1:0] lo, hi, tgt;
    case ($urandom_range(0, 5))
      0: begin lo = MinBits; hi = MaxBits; end
      // crossed limits
      1: begin
        lo = $urandom_range(1, 16) * 65536;
        hi = -int'($urandom_range(1, 16) * 65536);
      end
      2: begin lo = $urandom(); hi = $urandom(); end
      default: begin
        lo = -int'($urandom_range(1, 64) * 65536);
        hi = $urandom_range(1, 64) * 65536;
      end
    endcase
    case ($urandom_range(0, 3))
      0:       tgt = $urandom();
      1:       tgt = $urandom_range(0, 1) ? MaxBits : MinBits;
      default: tgt = small_q(16);
    endcase
    if ($urandom_range(0, 3) != 0) write_cfg(pidaw_pkg::RegGainP, pick_gain());
    if ($urandom_range(0, 3) != 0) write_cfg(pidaw_pkg::RegGainI, pick_gain());
    if ($urandom_range(0, 3) != 0) write_cfg(pidaw_pkg::RegGainD, pick_gain());
    if ($urandom_range(0, 3) != 0) write_cfg(pidaw_pkg::RegOutUpper, hi);
    if ($urandom_range(0, 3) != 0) write_cfg(pidaw_pkg::RegOutLower, lo);
    // a target write also clears the integral, so sometimes keep it
    if ($urandom_range(0, 1) != 0) write_cfg(pidaw_pkg::RegTarget, tgt);
    if ($urandom_range(0, 4) == 0) write_cfg($urandom_range(0, 1) ? IdxSpareLo : IdxSpareHi, $urandom());
    steady_in  = ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
  endtask

  // mostly plausible loop traffic near the setpoint, plus noise and edge values
  task automatic random_request();
    logic [DW-1:0]  meas;
    logic [MsW-1:0] ms;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    meas = sb.target[DW-1:0] + small_q(4);
    ms   = MsW'($urandom_range(1, 50));
    if (pick >= 70 && pick < 80) begin
      meas = $urandom();
      ms   = MsW'($urandom());
    end else if (pick >= 80 && pick < 85) begin
      meas = $urandom();
      ms   = '0;
    end else if (pick >= 85 && pick < 90) begin
      meas = $urandom_range(0, 1) ? MaxBits : MinBits;
      case ($urandom_range(0, 2))
        0:       ms = MsW'(1);
        1:       ms = '1;
        default: ms = MsW'($urandom());
      endcase
    end else if (pick >= 90) begin
      ms = MsW'($urandom_range(1, 65535));
    end
    send_request(meas, ms);
  endtask

  // result side: random stall per result, none in a steady phase, checked at the accepting edge
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, MaxGap);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(drive_o, skipped_o);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: pure proportional, full output range
    send_request('0, 16'd1);
    send_request(MaxBits, 16'd1);
    // error saturates when the sample is most negative
    send_request(MinBits, '1);
    // zero elapsed time skips the update
    send_request(32'd12345, '0);
    send_request(-int'(5 * 65536), 16'd1000);
    drain(TailCycles);

    // extreme gains and setpoint, products and slope saturate
    write_cfg(pidaw_pkg::RegGainP, MinBits);
    write_cfg(pidaw_pkg::RegGainI, MaxBits);
    write_cfg(pidaw_pkg::RegGainD, MaxBits);
    write_cfg(pidaw_pkg::RegTarget, MaxBits);
    send_request(MinBits, 16'd1);
    send_request(MaxBits, '1);
    send_request('0, '0);
    send_request(MinBits, 16'd7);
    drain(TailCycles);

    // moderate loop: integral builds up within the limits, spare indexes ignored
    write_cfg(pidaw_pkg::RegGainP, 2 * OneQ);
    write_cfg(pidaw_pkg::RegGainI, OneQ);
    write_cfg(pidaw_pkg::RegGainD, -int'(OneQ));
    write_cfg(pidaw_pkg::RegOutLower, -int'(10 * 65536));
    write_cfg(pidaw_pkg::RegOutUpper, 10 * 65536);
    write_cfg(pidaw_pkg::RegTarget, 3 * OneQ);
    write_cfg(IdxSpareLo, MaxBits);
    write_cfg(IdxSpareHi, MinBits);
    repeat (4) send_request('0, 16'd10);
    send_request(3 * OneQ, 16'd3);
    drain(TailCycles);

    // crossed limits: lower one wins below it
    write_cfg(pidaw_pkg::RegOutLower, 5 * OneQ);
    write_cfg(pidaw_pkg::RegOutUpper, -int'(5 * 65536));
    send_request('0, 16'd10);
    send_request(10 * 65536, 16'd10);
    send_request(-int'(10 * 65536), '0);
    send_request(MaxBits, '1);
    drain(TailCycles);

    for (int p = 0; p < RandomPhases; p++) begin
      random_config();
      for (int n = 0; n < PhaseRequests; n++) begin
        random_request();
        // occasional full pause of the sender mid-phase
        if ($urandom_range(0, 39) == 0) drain(0);
      end
      drain(TailCycles);
    end

    drain(TailCycles);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
